// ===== rtl/core/header_field_extractor_macros.svh =====
// assertion macros for the header field extractor rtl
`ifndef HEADER_FIELD_EXTRACTOR_MACROS_SVH
`define HEADER_FIELD_EXTRACTOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled during reset
`define HFE_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hfe assertion failed");
// next-cycle implication, disabled during reset
`define HFE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hfe assertion failed");
`else
`define HFE_ASSERT_NOW(name, clk, rst, ante, cons)
`define HFE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/hfe_pkg.sv =====
// types, constants and helpers for the header field extractor
`default_nettype none

package hfe_pkg;

   localparam int MAX_KEY_BYTES = 16;
   localparam int KEY_POS_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int KEY_LEN_W     = 5;
   localparam int KEY_WORD_W    = 64;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_IDX_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH   = 2'd2;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [2:0] {
      MODE_MATCH = 3'd0,
      MODE_SKIP  = 3'd1,
      MODE_DROP  = 3'd2,
      MODE_SEP   = 3'd3,
      MODE_WS    = 3'd4,
      MODE_VALUE = 3'd5,
      MODE_DONE  = 3'd6
   } parse_mode_type;

   typedef struct packed {
      logic [7:0] hdr_byte;
      logic       block_end;
   } req_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       is_value;
      logic       found;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [KEY_LEN_W-1:0]  key_length;
      logic [KEY_WORD_W-1:0] key_bytes_high;
      logic [KEY_WORD_W-1:0] key_bytes_low;
   } cfg_type;

   // space, tab, line feed, vertical tab, form feed, carriage return
   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hfe_csr.sv =====
// configuration register file with apb-style access
`default_nettype none

module hfe_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [hfe_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [hfe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [hfe_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready,
   output hfe_pkg::cfg_type                   cfg
);
   import hfe_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [CSR_IDX_W-1:0] idx;
   logic                 wr_en;

   assign idx    = paddr[CSR_ADDR_W-1:3];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_KEY_LENGTH: cfg_in.key_length     = pwdata[KEY_LEN_W-1:0];
            CSR_KEY_LOW:    cfg_in.key_bytes_low  = pwdata[KEY_WORD_W-1:0];
            CSR_KEY_HIGH:   cfg_in.key_bytes_high = pwdata[KEY_WORD_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_KEY_LENGTH: prdata = CSR_DATA_W'(cfg_ff.key_length);
         CSR_KEY_LOW:    prdata = CSR_DATA_W'(cfg_ff.key_bytes_low);
         CSR_KEY_HIGH:   prdata = CSR_DATA_W'(cfg_ff.key_bytes_high);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_length     <= KEY_LEN_W'(1);
         cfg_ff.key_bytes_low  <= '0;
         cfg_ff.key_bytes_high <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/hfe_parse.sv =====
// line parser state machine: key match, skip, separator, value emit
`default_nettype none

module hfe_parse (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire hfe_pkg::req_type item,
   input  wire hfe_pkg::cfg_type cfg,
   output hfe_pkg::rsp_type      rsp,
   output logic                  has_rsp
);
   import hfe_pkg::*;

   parse_mode_type                        mode_ff;
   parse_mode_type                        mode_in;
   logic [KEY_POS_W-1:0]                  pos_ff;
   logic [KEY_POS_W-1:0]                  pos_in;
   logic [KEY_LEN_W-1:0]                  eff_len;
   logic [KEY_POS_W-1:0]                  cur_pos;
   logic [KEY_LEN_W-1:0]                  next_pos;
   logic [2*KEY_WORD_W-1:0]               key_all;
   logic [MAX_KEY_BYTES-1:0][7:0]         key_arr;
   logic [7:0]                            key_byte;

   assign key_all = {cfg.key_bytes_high, cfg.key_bytes_low};
   assign key_arr = key_all[MAX_KEY_BYTES*8-1:0];

   // zero length acts as one, oversize clamps to the maximum
   always_comb begin
      if (cfg.key_length == '0) begin
         eff_len = KEY_LEN_W'(1);
      end else if (cfg.key_length > KEY_LEN_W'(MAX_KEY_BYTES)) begin
         eff_len = KEY_LEN_W'(MAX_KEY_BYTES);
      end else begin
         eff_len = cfg.key_length;
      end
   end

   assign cur_pos  = (KEY_LEN_W'(pos_ff) >= eff_len) ? '0 : pos_ff;
   assign key_byte = key_arr[cur_pos];
   assign next_pos = KEY_LEN_W'(cur_pos) + KEY_LEN_W'(1);

   always_comb begin
      mode_in = mode_ff;
      pos_in  = pos_ff;
      rsp     = '0;
      has_rsp = 1'b0;
      if (item.block_end) begin
         mode_in = MODE_MATCH;
         pos_in  = '0;
         unique case (mode_ff)
            MODE_DONE: has_rsp = 1'b0;
            MODE_SEP, MODE_WS, MODE_VALUE: begin
               has_rsp   = 1'b1;
               rsp.found = 1'b1;
               rsp.last  = 1'b1;
            end
            default: begin
               has_rsp  = 1'b1;
               rsp.last = 1'b1;
            end
         endcase
      end else begin
         unique case (mode_ff)
            MODE_MATCH: begin
               if (item.hdr_byte == key_byte) begin
                  if (next_pos >= eff_len) begin
                     mode_in = MODE_SEP;
                     pos_in  = '0;
                  end else begin
                     pos_in = next_pos[KEY_POS_W-1:0];
                  end
               end else begin
                  pos_in  = '0;
                  mode_in = (item.hdr_byte == CH_CR) ? MODE_DROP : MODE_SKIP;
               end
            end
            MODE_SKIP: begin
               if (item.hdr_byte == CH_CR) begin
                  mode_in = MODE_DROP;
               end
            end
            MODE_DROP: begin
               mode_in = MODE_MATCH;
               pos_in  = '0;
            end
            MODE_SEP: mode_in = MODE_WS;
            MODE_WS: begin
               if (!is_ws(item.hdr_byte)) begin
                  mode_in        = MODE_VALUE;
                  has_rsp        = 1'b1;
                  rsp.value_byte = item.hdr_byte;
                  rsp.is_value   = 1'b1;
               end
            end
            MODE_VALUE: begin
               has_rsp = 1'b1;
               if (item.hdr_byte == CH_CR) begin
                  mode_in   = MODE_DONE;
                  rsp.found = 1'b1;
                  rsp.last  = 1'b1;
               end else begin
                  rsp.value_byte = item.hdr_byte;
                  rsp.is_value   = 1'b1;
               end
            end
            MODE_DONE: mode_in = MODE_DONE;
            default: begin
               mode_in = MODE_MATCH;
               pos_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MATCH;
         pos_ff  <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/header_field_extractor.sv =====
// top level of the header field extractor: input register, parser, result register
`default_nettype none

// header field extractor: header text comes in one byte per req transfer,
// with block_end marking the end of a header block. the block compares each
// line start with the configured key (a longer name that begins with the key
// also matches), skips lines that do not match, and for the matching line
// drops one separator byte, skips whitespace and returns the value bytes, one
// per rsp transfer with is_value set. a final rsp transfer with last set
// reports found; a block with no match gives last with found clear. one
// byte is taken every cycle unless req_stall is high: each byte lands in
// the input register, then passes the parser state machine and, if it
// makes a result, is loaded into the result register. a stalled result
// does not block input unless a second result is waiting behind it. key
// registers sit at byte addresses 0 (key_length), 8 (key bytes 0 to 7)
// and 16 (key bytes 8 to 15). the user must see that they are written
// only while no byte is in flight; the block itself does not enforce it.

`include "header_field_extractor_macros.svh"

module header_field_extractor (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // byte input channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire hfe_pkg::req_type               req_data,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output hfe_pkg::rsp_type                    rsp_data,
   // configuration port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [hfe_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [hfe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [hfe_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);
   import hfe_pkg::*;

   cfg_type cfg;

   // input register
   logic    in_vld_ff;
   logic    in_vld_in;
   req_type in_data_ff;

   // result register
   logic    out_vld_ff;
   logic    out_vld_in;
   rsp_type out_data_ff;

   // parser outputs for the byte in the input register
   rsp_type step_rsp;
   logic    step_has_rsp;

   logic    out_free;
   logic    consume;
   logic    req_take;
   logic    rsp_load;

   // held result kinds, for the checks below
   logic    out_value;
   logic    out_closes;

   hfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hfe_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (consume),
      .item    (in_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp),
      .has_rsp (step_has_rsp)
   );

   // result register frees up when empty or when its transfer completes
   assign out_free = !out_vld_ff || !rsp_stall;

   // a byte that makes no result never waits on the result side
   assign consume   = in_vld_ff && (out_free || !step_has_rsp);
   assign rsp_load  = consume && step_has_rsp;
   assign req_stall = in_vld_ff && !consume;
   assign req_take  = req_valid && !req_stall;

   assign in_vld_in  = req_take || (in_vld_ff && !consume);
   assign out_vld_in = rsp_load || (out_vld_ff && rsp_stall);

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   assign out_value  = out_vld_ff && out_data_ff.is_value;
   assign out_closes = out_data_ff.last || out_data_ff.found;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (rsp_load) begin
         out_data_ff <= step_rsp;
      end
   end

   // a value byte result never closes the search
   `HFE_ASSERT_NOW(a_value_not_last, clock, reset, out_value, !out_closes)
   // a byte held back in the input register is still there next cycle
   `HFE_ASSERT_NEXT(a_held_byte_kept, clock, reset, in_vld_ff && !consume, in_vld_ff)
   // a stalled result is never dropped
   `HFE_ASSERT_NEXT(a_result_kept, clock, reset, out_vld_ff && rsp_stall, out_vld_ff)
   // a new result is only loaded into a free result register
   `HFE_ASSERT_NOW(a_load_free_slot, clock, reset, rsp_load, out_free)

endmodule

`default_nettype wire

// ===== sim/header_field_extractor_tb.sv =====
// self-checking testbench for the header field extractor: directed and random header blocks vs a local parser
module header_field_extractor_tb;
   import hfe_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int PHASE_COUNT   = 10;
   localparam int RANDOM_ITEMS  = 1750;
   // long receiver hold-off, started once enough bytes have gone through
   localparam int HOLD_AT       = 700;
   localparam int HOLD_CYCLES   = 300;
   // a byte with no result may still be in flight after the last result
   localparam int SETTLE_CYCLES = 10;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int RUN_LIMIT     = 2_000_000;

   typedef enum {KEY_ASCII, KEY_ANY, KEY_ONES, KEY_ZEROS} key_style_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   header_field_extractor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // local copy of the key registers, as left by reset
   logic [KEY_LEN_W-1:0]  key_len_reg  = 5'd1;
   logic [KEY_WORD_W-1:0] key_low_reg  = '0;
   logic [KEY_WORD_W-1:0] key_high_reg = '0;
   // local copy of the parser state
   parse_mode_type        mode_now     = MODE_MATCH;
   int unsigned           match_pos    = 0;

   req_type pending_bytes[$];     // header bytes waiting for the driver
   rsp_type expected_results[$];  // value bytes and final reports still owed
   int      error_count    = 0;
   int      accepted_bytes = 0;

   // driver and receiver state
   int      gap_left      = 0;
   int      burst_left    = 0;
   int      hold_left     = 0;
   logic    hold_done     = 1'b0;
   int      pattern_left  = 0;
   int      stall_percent = 0;
   rsp_type step_result;
   rsp_type wanted_result;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // ---------------------------------------------------------------
   // parser prediction
   // ---------------------------------------------------------------

   // zero acts as one, anything past the key buffer as the full buffer
   function automatic int unsigned active_key_len();
      int unsigned n;
      n = key_len_reg;
      if (n < 1) n = 1;
      if (n > MAX_KEY_BYTES) n = MAX_KEY_BYTES;
      return n;
   endfunction

   function automatic logic [7:0] key_char(input int unsigned pos);
      logic [KEY_WORD_W-1:0] word;
      word = (pos < 8) ? key_low_reg : key_high_reg;
      return word[(pos % 8) * 8 +: 8];
   endfunction

   // space plus tab through carriage return
   function automatic logic is_blank(input logic [7:0] c);
      case (c)
         8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // advances the parser copy by one byte; returns 1 when a result is owed
   function automatic bit extract_step(input req_type item, output rsp_type res);
      int unsigned    len;
      int unsigned    pos;
      parse_mode_type was;
      res = '0;
      if (item.block_end) begin
         // every block end rewinds to line start matching
         was       = mode_now;
         mode_now  = MODE_MATCH;
         match_pos = 0;
         if (was == MODE_DONE) return 1'b0;
         res.found = (was == MODE_SEP) || (was == MODE_WS) || (was == MODE_VALUE);
         res.last  = 1'b1;
         return 1'b1;
      end
      case (mode_now)
         MODE_MATCH: begin
            len = active_key_len();
            pos = (match_pos >= len) ? 0 : match_pos;
            if (item.hdr_byte == key_char(pos)) begin
               pos++;
               if (pos >= len) begin
                  // whole key seen, longer names match too
                  mode_now  = MODE_SEP;
                  match_pos = 0;
               end else begin
                  match_pos = pos;
               end
            end else begin
               match_pos = 0;
               if (item.hdr_byte == CH_CR) mode_now = MODE_DROP;
               else mode_now = MODE_SKIP;
            end
         end
         MODE_SKIP: begin
            if (item.hdr_byte == CH_CR) mode_now = MODE_DROP;
         end
         MODE_DROP: begin
            mode_now  = MODE_MATCH;
            match_pos = 0;
         end
         MODE_SEP: begin
            mode_now = MODE_WS;
         end
         MODE_WS: begin
            if (!is_blank(item.hdr_byte)) begin
               mode_now       = MODE_VALUE;
               res.value_byte = item.hdr_byte;
               res.is_value   = 1'b1;
               return 1'b1;
            end
         end
         MODE_VALUE: begin
            if (item.hdr_byte == CH_CR) begin
               mode_now  = MODE_DONE;
               res.found = 1'b1;
               res.last  = 1'b1;
            end else begin
               res.value_byte = item.hdr_byte;
               res.is_value   = 1'b1;
            end
            return 1'b1;
         end
         MODE_DONE: begin
         end
         default: begin
            mode_now  = MODE_MATCH;
            match_pos = 0;
         end
      endcase
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------

   function automatic void queue_byte(input logic [7:0] b);
      req_type item;
      item.hdr_byte  = b;
      item.block_end = 1'b0;
      pending_bytes.push_back(item);
   endfunction

   // the byte that travels with a block end is random, it must be ignored
   function automatic void queue_end();
      req_type item;
      item.hdr_byte  = 8'($urandom_range(0, 255));
      item.block_end = 1'b1;
      pending_bytes.push_back(item);
   endfunction

   function automatic logic [7:0] name_char();
      case ($urandom_range(0, 4))
         0: return 8'h2D;
         1, 2: return 8'($urandom_range(8'h41, 8'h5A));
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 5))
         0: return CH_TAB;
         1: return 8'h0A;
         2: return 8'h0B;
         3: return 8'h0C;
         4: return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   // mostly printable, sometimes any byte (a carriage return ends the value)
   function automatic logic [7:0] value_char();
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h21, 8'h7E));
      return 8'($urandom_range(0, 255));
   endfunction

   // one header block of a few lines, returns the number of transfers queued
   function automatic int queue_block();
      logic [7:0] text[$];
      int         lines;
      int         kind;
      int         klen;
      int         n;
      int         i;
      int         j;
      int         cut;
      klen  = active_key_len();
      lines = $urandom_range(0, 5);
      for (i = 0; i < lines; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            // the wanted field, now and then under a longer name
            for (j = 0; j < klen; j++) text.push_back(key_char(j));
            if ($urandom_range(0, 2) == 0) begin
               n = $urandom_range(1, 3);
               for (j = 0; j < n; j++) text.push_back(name_char());
            end
            if ($urandom_range(0, 4) == 0) text.push_back(8'($urandom_range(0, 255)));
            else text.push_back(8'h3A);
            n = $urandom_range(0, 3);
            for (j = 0; j < n; j++) text.push_back(blank_char());
            n = $urandom_range(0, 10);
            for (j = 0; j < n; j++) text.push_back(value_char());
         end else if (kind < 8) begin
            // another field, possibly sharing the first key bytes
            n = $urandom_range(0, klen - 1);
            for (j = 0; j < n; j++) text.push_back(key_char(j));
            n = $urandom_range(1, 6);
            for (j = 0; j < n; j++) text.push_back(name_char());
            text.push_back(8'h3A);
            text.push_back(CH_SPACE);
            n = $urandom_range(0, 8);
            for (j = 0; j < n; j++) text.push_back(value_char());
         end else begin
            // raw noise over the whole byte range
            n = $urandom_range(1, 6);
            for (j = 0; j < n; j++) text.push_back(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 7) != 0) text.push_back(CH_CR);
         if ($urandom_range(0, 3) != 0) text.push_back(8'h0A);
      end
      // some blocks end part way through a line
      if (text.size() > 0 && $urandom_range(0, 3) == 0) begin
         cut = $urandom_range(0, text.size() - 1);
         while (text.size() > cut) void'(text.pop_back());
      end
      foreach (text[k]) queue_byte(text[k]);
      queue_end();
      return text.size() + 1;
   endfunction

   // ---------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------

   // setup then access phase; the register takes the value at the access edge
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [KEY_WORD_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CSR_KEY_LENGTH: key_len_reg  = value[KEY_LEN_W-1:0];
         CSR_KEY_LOW:    key_low_reg  = value;
         CSR_KEY_HIGH:   key_high_reg = value;
         default: ;
      endcase
   endtask

   task automatic program_key(input logic [KEY_LEN_W-1:0] len, input key_style_type style);
      logic [2*KEY_WORD_W-1:0] key_bits;
      int                      i;
      for (i = 0; i < MAX_KEY_BYTES; i++) begin
         case (style)
            KEY_ASCII: key_bits[i*8 +: 8] = name_char();
            KEY_ANY:   key_bits[i*8 +: 8] = 8'($urandom_range(0, 255));
            KEY_ONES:  key_bits[i*8 +: 8] = 8'hFF;
            default:   key_bits[i*8 +: 8] = 8'h00;
         endcase
      end
      write_register(CSR_KEY_LENGTH, KEY_WORD_W'(len));
      write_register(CSR_KEY_LOW, key_bits[KEY_WORD_W-1:0]);
      write_register(CSR_KEY_HIGH, key_bits[2*KEY_WORD_W-1:KEY_WORD_W]);
   endtask

   // sender pause: nothing queued, nothing owed, then a few cycles for
   // bytes that make no result; sampled on the falling edge
   task automatic wait_idle();
      int waited;
      waited = 0;
      while ((pending_bytes.size() != 0 || req_valid || expected_results.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
         expected_results.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // driver: bursts of transfers with random gaps, fed from pending_bytes
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   <= 0;
         burst_left <= 0;
      end else if (!req_valid || !req_stall) begin
         // transfer taken at this edge: predict what it causes
         if (req_valid) begin
            if (extract_step(req_data, step_result)) expected_results.push_back(step_result);
            accepted_bytes <= accepted_bytes + 1;
         end
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_data  <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               // new burst; a quarter of the time back to back
               burst_left <= $urandom_range(1, 40);
               if ($urandom_range(0, 3) == 0) gap_left <= 0;
               else gap_left <= $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver stall: stretches of fixed stall rate, one long hold-off
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall     <= 1'b0;
         hold_left     <= 0;
         hold_done     <= 1'b0;
         pattern_left  <= 0;
         stall_percent <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted_bytes >= HOLD_AT && pending_bytes.size() > 60) begin
         // sender keeps going, so the block backs up and stalls its input
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            pattern_left <= $urandom_range(20, 120);
            case ($urandom_range(0, 3))
               0: stall_percent <= 0;
               1: stall_percent <= 30;
               2: stall_percent <= 60;
               default: stall_percent <= 90;
            endcase
         end else begin
            pattern_left <= pattern_left - 1;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_percent);
      end
   end

   // ---------------------------------------------------------------
   // monitor: each result transfer against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", rsp_data));
         end else begin
            wanted_result = expected_results.pop_front();
            if (rsp_data.value_byte !== wanted_result.value_byte)
               report_mismatch($sformatf("value_byte %h, expected %h",
                                         rsp_data.value_byte, wanted_result.value_byte));
            if (rsp_data.is_value !== wanted_result.is_value)
               report_mismatch($sformatf("is_value %b, expected %b",
                                         rsp_data.is_value, wanted_result.is_value));
            if (rsp_data.found !== wanted_result.found)
               report_mismatch($sformatf("found %b, expected %b",
                                         rsp_data.found, wanted_result.found));
            if (rsp_data.last !== wanted_result.last)
               report_mismatch($sformatf("last %b, expected %b",
                                         rsp_data.last, wanted_result.last));
         end
      end
   end

   // ---------------------------------------------------------------
   // sequence: reset, directed blocks, then random phases per key setting
   // ---------------------------------------------------------------
   initial begin
      int            phase;
      int            queued;
      key_style_type style;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset key: one byte of zero
      queue_end();                                     // end while matching
      queue_byte(8'h41); queue_end();                  // end while skipping a line
      queue_byte(8'h41); queue_byte(CH_CR); queue_end(); // end on the dropped byte
      queue_byte(8'h00); queue_end();                  // key matched, end before separator
      // zero byte as key, all six blanks skipped, value ff 00, then ignored tail
      queue_byte(8'h00); queue_byte(8'h3A); queue_byte(CH_SPACE); queue_byte(CH_TAB);
      queue_byte(8'h0A); queue_byte(8'h0B); queue_byte(8'h0C); queue_byte(CH_CR);
      queue_byte(8'hFF); queue_byte(8'h00); queue_byte(CH_CR); queue_byte(8'h41);
      queue_end();                                     // end after the found report
      queue_byte(8'h00); queue_byte(8'h3A); queue_byte(8'h76); queue_end(); // end in value
      wait_idle();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: program_key(5'd16, KEY_ASCII);
            1: program_key(5'd0, KEY_ASCII);   // zero length acts as one
            2: program_key(5'd31, KEY_ONES);   // oversized length acts as sixteen
            3: program_key(5'd16, KEY_ZEROS);
            4: program_key(5'd1, KEY_ASCII);
            default: begin
               if ($urandom_range(0, 1) == 0) style = KEY_ASCII;
               else style = KEY_ANY;
               program_key(5'($urandom_range(1, 16)), style);
            end
         endcase
         queued = 0;
         while (queued < RANDOM_ITEMS / PHASE_COUNT) queued += queue_block();
         wait_idle();
      end

      if (error_count == 0) begin
         $display("[header_field_extractor] OK");
      end else begin
         $display("[header_field_extractor] ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #(RUN_LIMIT);
      $display("[header_field_extractor] ERROR");
      $finish;
   end

endmodule
